// ----- src/law_pkg.sv -----
`timescale 1ns / 1ps

package law_pkg;

    // Step direction codes carried in the data beat
    typedef enum logic [1:0] {
        DIR_WEST  = 2'd0,
        DIR_NORTH = 2'd1,
        DIR_EAST  = 2'd2,
        DIR_SOUTH = 2'd3
    } dir_t;

    // Item kind carried in tuser
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SEED_X = 1'b0;
    localparam logic CFG_SEED_Y = 1'b1;

    localparam int SEED_W  = 6;
    localparam int COORD_W = 6;
    localparam logic [SEED_W-1:0] SEED_RESET = 6'd32;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

endpackage

// ----- src/lattice_aggregation_walker.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Ports                       Beat contents (lowest bit first)
// s_        in   s_tvalid/s_tready/s_tdata   tdata: direction[1:0]; tuser: op
// m_        out  m_tvalid/m_tready/m_tdata   tdata: walker_x, walker_y,
//                                            deposited, left_grid, finished
// cfg_      in   cfg_wr_en/cfg_addr/cfg_wdata seed_x (0), seed_y (1)
//
// One item per cycle while s_tready is high; each result is registered.
// The grid is a row memory with two registered read ports (rows r-2, r+2)
// plus three row registers around the walker; a deposit is one row write.
// aresetn is synchronous: grid empty, walker at the launch point, seeds 32.
// A restart drops all row valid bits at once and writes the seed row.
// A two-entry output stage keeps s_tready high until two results are waiting.
module lattice_aggregation_walker #(
    parameter int GRID_SIZE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [law_pkg::IN_DATA_W-1:0] s_tdata,    // [1:0] direction, [7:2] zero
    input  logic        s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [5:0] walker_x, [11:6] walker_y,
                                    // [12] deposited, [13] left_grid,
                                    // [14] finished, [15] zero
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata
);

    localparam int CW     = $clog2(GRID_SIZE);
    localparam int LAUNCH = GRID_SIZE / 4;
    localparam logic [CW-1:0] LAUNCH_C = CW'(LAUNCH);
    localparam logic [CW-1:0] LAST_C   = CW'(GRID_SIZE - 1);

    typedef logic [GRID_SIZE-1:0] row_t;

    // Configuration
    logic [law_pkg::SEED_W-1:0] seed_x_reg;
    logic [law_pkg::SEED_W-1:0] seed_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_x_reg <= law_pkg::SEED_RESET;
            seed_y_reg <= law_pkg::SEED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                law_pkg::CFG_SEED_X: seed_x_reg <= cfg_wdata;
                law_pkg::CFG_SEED_Y: seed_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Walker state
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          done_flag_reg, done_flag_next;

    // Rows r-1, r, r+1 around the walker, and rows launch-2 .. launch+2
    row_t win_reg [3];
    row_t win_next [3];
    row_t launch_reg [5];
    row_t launch_next [5];

    // Row memory and its bookkeeping
    row_t          grid_mem [GRID_SIZE];
    row_t          row_valid_reg, row_valid_next;
    row_t          rd_lo_data_reg, rd_hi_data_reg;
    logic [CW-1:0] rd_lo_addr_reg, rd_hi_addr_reg;
    logic          rd_lo_ok_reg, rd_hi_ok_reg;
    logic [CW-1:0] rd_lo_addr, rd_hi_addr;
    logic          rd_lo_ok, rd_hi_ok;
    logic [CW:0]   rd_hi_sum;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    row_t          wr_data;
    logic          wr_valid_reg;
    logic [CW-1:0] wr_addr_reg;
    row_t          wr_data_reg;

    // Output stage with skid
    logic [law_pkg::OUT_DATA_W-1:0] out_data_reg, skid_data_reg, result;
    logic out_valid_reg, skid_valid_reg;

    logic          s_acc;
    logic          is_restart, step_live, off_grid, touch, stick;
    law_pkg::dir_t dir;
    logic [CW-1:0] step_row, step_col, col_m, col_p;
    logic [CW-1:0] seed_row, seed_col;
    logic [CW+5:0] seed_x_w, seed_y_w, out_x_w, out_y_w;
    logic          seed_ok;
    row_t          view [5];
    row_t          up_row, same_row, dn_row, col_bit, seed_bit, seed_plant;

    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign is_restart = (s_tuser == law_pkg::OP_RESTART);
    assign step_live  = s_acc && !is_restart && !done_flag_reg;
    assign dir        = law_pkg::dir_t'(s_tdata[1:0]);

    assign seed_x_w = (CW+6)'(seed_x_reg);
    assign seed_y_w = (CW+6)'(seed_y_reg);
    assign seed_row = seed_x_w[CW-1:0];
    assign seed_col = seed_y_w[CW-1:0];
    assign seed_ok  = (32'(seed_x_reg) < GRID_SIZE) && (32'(seed_y_reg) < GRID_SIZE);
    assign seed_bit = row_t'(1) << seed_col;

    // Rows r-2 and r+2: masked by range and row valid, bypassed from last write
    always_comb begin
        view[1] = win_reg[0];
        view[2] = win_reg[1];
        view[3] = win_reg[2];
        view[0] = '0;
        view[4] = '0;
        if (rd_lo_ok_reg && row_valid_reg[rd_lo_addr_reg]) begin
            view[0] = (wr_valid_reg && wr_addr_reg == rd_lo_addr_reg) ?
                      wr_data_reg : rd_lo_data_reg;
        end
        if (rd_hi_ok_reg && row_valid_reg[rd_hi_addr_reg]) begin
            view[4] = (wr_valid_reg && wr_addr_reg == rd_hi_addr_reg) ?
                      wr_data_reg : rd_hi_data_reg;
        end
    end

    // Move and neighbor check
    always_comb begin
        step_row = row_reg;
        step_col = col_reg;
        off_grid = 1'b0;
        up_row   = view[1];
        same_row = view[2];
        dn_row   = view[3];
        case (dir)
            law_pkg::DIR_WEST: begin
                step_row = row_reg - 1'b1;
                off_grid = (row_reg == '0);
                up_row   = view[0];
                same_row = view[1];
                dn_row   = view[2];
            end
            law_pkg::DIR_NORTH: begin
                step_col = col_reg + 1'b1;
                off_grid = (col_reg == LAST_C);
            end
            law_pkg::DIR_EAST: begin
                step_row = row_reg + 1'b1;
                off_grid = (row_reg == LAST_C);
                up_row   = view[2];
                same_row = view[3];
                dn_row   = view[4];
            end
            law_pkg::DIR_SOUTH: begin
                step_col = col_reg - 1'b1;
                off_grid = (col_reg == '0);
            end
            default: ;
        endcase
    end

    assign col_m   = (step_col == '0) ? '0 : step_col - 1'b1;
    assign col_p   = (step_col == LAST_C) ? LAST_C : step_col + 1'b1;
    assign touch   = up_row[step_col] || dn_row[step_col] ||
                     (step_col != '0 && same_row[col_m]) ||
                     (step_col != LAST_C && same_row[col_p]);
    assign stick   = step_live && !off_grid && touch;
    assign col_bit = row_t'(1) << step_col;

    // Grid update
    always_comb begin
        wr_en          = 1'b0;
        wr_addr        = step_row;
        wr_data        = same_row | col_bit;
        row_valid_next = row_valid_reg;
        seed_plant     = '0;
        for (int k = 0; k < 5; k++) begin
            launch_next[k] = launch_reg[k];
        end
        if (s_acc && is_restart) begin
            wr_en          = seed_ok;
            wr_addr        = seed_row;
            wr_data        = seed_bit;
            row_valid_next = '0;
            if (seed_ok) begin
                row_valid_next[seed_row] = 1'b1;
            end
            for (int k = 0; k < 5; k++) begin
                seed_plant     = (seed_ok && int'(seed_row) == LAUNCH - 2 + k) ?
                                 seed_bit : '0;
                launch_next[k] = seed_plant;
            end
        end else if (stick) begin
            wr_en                    = 1'b1;
            row_valid_next[step_row] = 1'b1;
            for (int k = 0; k < 5; k++) begin
                if (int'(step_row) == LAUNCH - 2 + k) begin
                    launch_next[k] = launch_reg[k] | col_bit;
                end
            end
        end
    end

    // Walker, window and finish flag
    always_comb begin
        row_next       = row_reg;
        col_next       = col_reg;
        done_flag_next = done_flag_reg;
        for (int k = 0; k < 3; k++) begin
            win_next[k] = win_reg[k];
        end
        if ((s_acc && is_restart) || (step_live && (off_grid || stick))) begin
            row_next = LAUNCH_C;
            col_next = LAUNCH_C;
            for (int k = 0; k < 3; k++) begin
                win_next[k] = launch_next[k+1];
            end
            if (is_restart) begin
                done_flag_next = 1'b0;
            end else if (stick) begin
                done_flag_next = launch_next[1][LAUNCH] || launch_next[3][LAUNCH] ||
                                 launch_next[2][LAUNCH-1] || launch_next[2][LAUNCH+1];
            end
        end else if (step_live) begin
            row_next = step_row;
            col_next = step_col;
            if (dir == law_pkg::DIR_EAST) begin
                win_next[0] = view[2];
                win_next[1] = view[3];
                win_next[2] = view[4];
            end else if (dir == law_pkg::DIR_WEST) begin
                win_next[0] = view[0];
                win_next[1] = view[1];
                win_next[2] = view[2];
            end
        end
    end

    // Read rows two away from where the walker will stand next cycle
    assign rd_hi_sum  = {1'b0, row_next} + (CW+1)'(2);
    assign rd_hi_ok   = rd_hi_sum <= (CW+1)'(GRID_SIZE - 1);
    assign rd_hi_addr = rd_hi_sum[CW-1:0];
    assign rd_lo_ok   = row_next >= CW'(2);
    assign rd_lo_addr = row_next - CW'(2);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        rd_lo_data_reg <= grid_mem[rd_lo_addr];
        rd_hi_data_reg <= grid_mem[rd_hi_addr];
    end

    always_ff @(posedge aclk) begin
        rd_lo_addr_reg <= rd_lo_addr;
        rd_hi_addr_reg <= rd_hi_addr;
        wr_addr_reg    <= wr_addr;
        wr_data_reg    <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= LAUNCH_C;
            col_reg       <= LAUNCH_C;
            done_flag_reg <= 1'b0;
            row_valid_reg <= '0;
            rd_lo_ok_reg  <= 1'b0;
            rd_hi_ok_reg  <= 1'b0;
            wr_valid_reg  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                win_reg[k] <= '0;
            end
            for (int k = 0; k < 5; k++) begin
                launch_reg[k] <= '0;
            end
        end else begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            done_flag_reg <= done_flag_next;
            row_valid_reg <= row_valid_next;
            rd_lo_ok_reg  <= rd_lo_ok;
            rd_hi_ok_reg  <= rd_hi_ok;
            wr_valid_reg  <= wr_en;
            for (int k = 0; k < 3; k++) begin
                win_reg[k] <= win_next[k];
            end
            for (int k = 0; k < 5; k++) begin
                launch_reg[k] <= launch_next[k];
            end
        end
    end

    // Result beat
    assign out_x_w = (CW+6)'(row_next);
    assign out_y_w = (CW+6)'(col_next);
    assign result  = {1'b0,
                      (!is_restart && done_flag_next),
                      (step_live && off_grid),
                      stick,
                      out_y_w[law_pkg::COORD_W-1:0],
                      out_x_w[law_pkg::COORD_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_acc;
            end
        end else if (s_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        if (s_acc && out_valid_reg && !m_tready) begin
            skid_data_reg <= result;
        end
    end

    // Checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output stage empty");

    a_restart_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_restart) |=> (row_reg == LAUNCH_C && col_reg == LAUNCH_C &&
                                   !done_flag_reg))
        else $error("restart did not relaunch walker");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_flag_reg && !(s_acc && is_restart)) |=> done_flag_reg)
        else $error("finish flag dropped without restart");

    a_stick_relaunch: assert property (@(posedge aclk) disable iff (!aresetn)
        stick |=> (row_reg == LAUNCH_C && col_reg == LAUNCH_C &&
                   row_valid_reg[$past(step_row)]))
        else $error("deposit did not mark its row or relaunch");

endmodule

// ----- verif/tb_lattice_aggregation_walker.sv -----
`timescale 1ns / 1ps

module tb_lattice_aggregation_walker;

    localparam int GRID         = 64;
    localparam int LAUNCH       = GRID / 4;
    localparam int TARGET_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic          op;
        law_pkg::dir_t dir;
    } walker_cmd_t;

    // Same bit order as m_tdata[14:0]
    typedef struct packed {
        logic                        fin;
        logic                        left_grid;
        logic                        dep;
        logic [law_pkg::COORD_W-1:0] wy;
        logic [law_pkg::COORD_W-1:0] wx;
    } walker_result_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic [7:0]                 s_tdata   = '0;     // [1:0] direction, [7:2] zero
    logic                       s_tuser   = 1'b0;   // [0] op
    logic                       m_tready  = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic                       cfg_addr  = 1'b0;
    logic [law_pkg::SEED_W-1:0] cfg_wdata = '0;
    logic                       s_tready;
    logic                       m_tvalid;
    logic [15:0]                m_tdata;    // [5:0] walker_x, [11:6] walker_y, [12] deposited,
                                            // [13] left_grid, [14] finished, [15] zero

    lattice_aggregation_walker #(.GRID_SIZE(GRID)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the grid, walker and seed registers
    bit                         occ [GRID][GRID];
    int                         walk_row     = LAUNCH;
    int                         walk_col     = LAUNCH;
    bit                         cluster_done = 1'b0;
    logic [law_pkg::SEED_W-1:0] seed_row     = law_pkg::SEED_RESET;
    logic [law_pkg::SEED_W-1:0] seed_col     = law_pkg::SEED_RESET;

    walker_cmd_t    pending_cmds[$];
    walker_result_t results_due[$];
    walker_cmd_t    in_flight;
    bit             cmd_live      = 1'b0;
    int             mismatches    = 0;
    int             queued_items  = 0;
    int             cycles        = 0;
    int             src_idle_pct  = 0;
    int             sink_idle_pct = 0;
    int             src_gap       = 0;
    int             sink_gap      = 0;

    function automatic bit occupied(int r, int c);
        if (r < 0 || r >= GRID || c < 0 || c >= GRID) return 1'b0;
        return occ[r][c];
    endfunction

    function automatic bit has_neighbor(int r, int c);
        return occupied(r - 1, c) || occupied(r + 1, c) ||
               occupied(r, c - 1) || occupied(r, c + 1);
    endfunction

    task automatic advance_walker(input walker_cmd_t cmd);
        int r;
        int c;
        walker_result_t res;
        res = '0;
        if (cmd.op == law_pkg::OP_RESTART) begin
            occ = '{default: 1'b0};
            if (seed_row < GRID && seed_col < GRID) occ[seed_row][seed_col] = 1'b1;
            walk_row     = LAUNCH;
            walk_col     = LAUNCH;
            cluster_done = 1'b0;
        end else if (!cluster_done) begin
            r = walk_row;
            c = walk_col;
            case (cmd.dir)
                law_pkg::DIR_WEST:  r = r - 1;
                law_pkg::DIR_NORTH: c = c + 1;
                law_pkg::DIR_EAST:  r = r + 1;
                default:            c = c - 1;
            endcase
            if (r < 0 || r >= GRID || c < 0 || c >= GRID) begin
                res.left_grid = 1'b1;
                r = LAUNCH;
                c = LAUNCH;
            end else if (has_neighbor(r, c)) begin
                occ[r][c] = 1'b1;
                res.dep   = 1'b1;
                r = LAUNCH;
                c = LAUNCH;
                if (has_neighbor(LAUNCH, LAUNCH)) cluster_done = 1'b1;
            end
            walk_row = r;
            walk_col = c;
        end
        res.wx  = walk_row[law_pkg::COORD_W-1:0];
        res.wy  = walk_col[law_pkg::COORD_W-1:0];
        res.fin = (cmd.op == law_pkg::OP_STEP) && cluster_done;
        results_due.push_back(res);
    endtask

    // A gap with the given percent chance: mostly short ones, a few long ones
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic void add_cmd(logic op, law_pkg::dir_t d);
        walker_cmd_t cmd;
        cmd.op  = op;
        cmd.dir = d;
        pending_cmds.push_back(cmd);
        queued_items++;
    endfunction

    // Lean toward the seed as seen from the launch point, else wander
    function automatic law_pkg::dir_t biased_dir(int tx, int ty);
        int dx;
        int dy;
        int ax;
        int ay;
        dx = tx - LAUNCH;
        dy = ty - LAUNCH;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if ($urandom_range(99) >= 65 || (ax + ay) == 0)
            return law_pkg::dir_t'($urandom_range(3));
        if ($urandom_range(ax + ay - 1) < ax)
            return (dx > 0) ? law_pkg::DIR_EAST : law_pkg::DIR_WEST;
        return (dy > 0) ? law_pkg::DIR_NORTH : law_pkg::DIR_SOUTH;
    endfunction

    task automatic write_seed(input logic idx, input logic [law_pkg::SEED_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == law_pkg::CFG_SEED_X) seed_row = val;
        else seed_col = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || cmd_live || results_due.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_walker(in_flight);
                cmd_live = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    in_flight = pending_cmds.pop_front();
                    cmd_live  = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tuser  <= in_flight.op;
                    s_tdata  <= {6'd0, in_flight.dir};
                    src_gap   = pick_gap(src_idle_pct);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side
    always @(posedge aclk) begin
        walker_result_t got;
        walker_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[14:0];
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h at %0t", m_tdata, $realtime);
                end else begin
                    want = results_due.pop_front();
                    if (got.wx !== want.wx || got.wy !== want.wy || got.dep !== want.dep ||
                        got.left_grid !== want.left_grid || got.fin !== want.fin) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at %0t: expected x=%0d y=%0d dep=%0d left=%0d ",
                                      "fin=%0d, got x=%0d y=%0d dep=%0d left=%0d fin=%0d"},
                                     $realtime, want.wx, want.wy, want.dep, want.left_grid,
                                     want.fin, got.wx, got.wy, got.dep, got.left_grid,
                                     got.fin);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = pick_gap(sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int phase;
        int tx;
        int ty;
        int walk_len;
        phase = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_pct  = 20;
        sink_idle_pct = 20;

        // Walk on an empty grid: nothing planted before the first restart
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_NORTH);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_EAST);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_SOUTH);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_WEST);
        add_cmd(law_pkg::OP_RESTART, law_pkg::DIR_WEST);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_EAST);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_NORTH);
        drain();

        // Seed two cells north of launch: first step deposits and finishes
        write_seed(law_pkg::CFG_SEED_X, 6'd16);
        write_seed(law_pkg::CFG_SEED_Y, 6'd18);
        add_cmd(law_pkg::OP_RESTART, law_pkg::DIR_SOUTH);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_NORTH);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_EAST);
        add_cmd(law_pkg::OP_STEP, law_pkg::DIR_WEST);
        drain();

        // Walk south off the grid through column zero
        write_seed(law_pkg::CFG_SEED_X, 6'd0);
        write_seed(law_pkg::CFG_SEED_Y, 6'd0);
        add_cmd(law_pkg::OP_RESTART, law_pkg::DIR_NORTH);
        repeat (17) add_cmd(law_pkg::OP_STEP, law_pkg::DIR_SOUTH);
        drain();

        while (queued_items < TARGET_ITEMS) begin
            case (phase % 7)
                0: begin tx = 0;  ty = 0;  end
                1: begin tx = 63; ty = 63; end
                2: begin tx = 0;  ty = 63; end
                3: begin tx = 63; ty = 0;  end
                4, 5: begin
                    tx = LAUNCH + $urandom_range(8) - 4;
                    ty = LAUNCH + $urandom_range(8) - 4;
                end
                default: begin
                    tx = $urandom_range(63);
                    ty = $urandom_range(63);
                end
            endcase
            write_seed(law_pkg::CFG_SEED_X, tx[law_pkg::SEED_W-1:0]);
            write_seed(law_pkg::CFG_SEED_Y, ty[law_pkg::SEED_W-1:0]);
            src_idle_pct  = pick_pct();
            sink_idle_pct = pick_pct();
            while (pending_cmds.size() < 150 && queued_items < TARGET_ITEMS) begin
                add_cmd(law_pkg::OP_RESTART, law_pkg::dir_t'($urandom_range(3)));
                walk_len = $urandom_range(120, 20);
                repeat (walk_len) begin
                    if ($urandom_range(99) < 10)
                        add_cmd(($urandom_range(15) == 0) ? law_pkg::OP_RESTART :
                                                            law_pkg::OP_STEP,
                                law_pkg::dir_t'($urandom_range(3)));
                    else
                        add_cmd(law_pkg::OP_STEP, biased_dir(tx, ty));
                end
            end
            drain();
            phase++;
        end

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/law_pkg.sv
src/lattice_aggregation_walker.sv
verif/tb_lattice_aggregation_walker.sv
